@@ sv/assert_macros.svh @@
// Assertion macros used by the queue block's controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define MRQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("queue block: property violated");

// Antecedent in one cycle implies consequent in the next.
`define MRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("queue block: next-cycle property violated");

`endif

@@ sv/mrq_pkg.sv @@
// Package: beat types, operation and status codes, controller command types.
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_OCC = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [3:0] QIU_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  queue_select;
    logic [31:0] descriptor_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] descriptor_out;
    logic [2:0]  source_queue;
    logic [10:0] occupancy;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } mrq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deq_hit;
  } mrq_sts_t;

endpackage

`default_nettype wire

@@ sv/mrq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mrq_ctrl.sv @@
// Controller: sequences accept, execute, store read and result beat.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire mrq_pkg::mrq_sts_t sts,
  output mrq_pkg::mrq_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   out_valid_r;

  assign cmd.load   = (state_r == S_IDLE) && in_valid && !in_stall_r;
  assign cmd.exec   = (state_r == S_EXEC);
  assign cmd.finish = (state_r == S_RDWAIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // a successful dequeue passes through S_RDWAIT for the store read
        state_nxt = sts.deq_hit ? S_RDWAIT : S_SEND;
      end
      S_RDWAIT: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_SEND);
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  `MRQ_ASSERT(a_hold_input_while_sending, clk, rst_n, out_valid_r |-> in_stall_r)
  `MRQ_ASSERT_NEXT(a_accept_stalls_input, clk, rst_n, cmd.load, in_stall_r && !out_valid_r)
  `MRQ_ASSERT_NEXT(a_read_then_send, clk, rst_n, cmd.finish, out_valid_r)

endmodule

`default_nettype wire

@@ sv/mrq_datapath.sv @@
// Datapath: ring pointers, priority pick, descriptor store and result register.
`timescale 1ns / 1ps
`default_nettype none

module mrq_datapath #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 2048,
  parameter int DESC_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  input  wire mrq_pkg::in_beat_t  in_beat,
  input  wire mrq_pkg::mrq_cmd_t  cmd,
  output mrq_pkg::mrq_sts_t       sts,
  output mrq_pkg::out_beat_t      out_beat
);

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = PTR_W + 1;
  localparam int AW     = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  logic [PTR_W-1:0]      head_r [NUM_QUEUES];
  logic [PTR_W-1:0]      tail_r [NUM_QUEUES];
  logic [3:0]            qiu_r;
  logic [1:0]            func_r;
  logic [QW-1:0]         idx_r;
  logic                  found_r;
  logic [DESC_WIDTH-1:0] desc_r;

  logic [1:0]            res_status_r;
  logic [31:0]           res_desc_r;
  logic [2:0]            res_src_r;
  logic [10:0]           res_occ_r;

  logic [NUM_QUEUES-1:0] nonempty;
  logic                  pick_found;
  logic [QW-1:0]         pick_idx;
  logic [QW-1:0]         sel_idx;
  logic [QW+2:0]         sel_wide;
  logic [DESC_WIDTH+31:0] din_wide;
  logic [DESC_WIDTH+31:0] dout_wide;
  logic [FILL_W+10:0]    occ_wide;
  logic [QW+2:0]         src_wide;

  logic [PTR_W-1:0]      cur_h;
  logic [PTR_W-1:0]      cur_t;
  logic [PTR_W-1:0]      h_adv;
  logic [PTR_W-1:0]      t_adv;
  logic                  full;
  logic [FILL_W-1:0]     fill;
  logic [AW-1:0]         base;
  logic                  ram_we;
  logic [DESC_WIDTH-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(1);
    return (s >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : s[PTR_W-1:0];
  endfunction

  // queue number modulo the queue count; at most eight subtract steps
  function automatic logic [2:0] sel_mod(input logic [2:0] s);
    logic [6:0] v;
    v = {4'd0, s};
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(NUM_QUEUES)) begin
        v = v - 7'(NUM_QUEUES);
      end
    end
    return v[2:0];
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      nonempty[i] = (head_r[i] != tail_r[i]);
    end
  end

  // highest-numbered non-empty queue below the in-use limit
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (nonempty[i] && (i < int'(qiu_r))) begin
        pick_found = 1'b1;
        pick_idx   = QW'(i);
      end
    end
  end

  assign sel_wide = {QW'(0), sel_mod(in_beat.queue_select)};
  assign sel_idx  = sel_wide[QW-1:0];
  assign din_wide = {DESC_WIDTH'(0), in_beat.descriptor_in};

  assign cur_h = head_r[idx_r];
  assign cur_t = tail_r[idx_r];
  assign h_adv = ptr_adv(cur_h);
  assign t_adv = ptr_adv(cur_t);
  assign full  = (cur_h == t_adv);
  assign fill  = (cur_h <= cur_t) ? ({1'b0, cur_t} - {1'b0, cur_h})
                                  : (FILL_W'(QUEUE_DEPTH) - {1'b0, cur_h} + {1'b0, cur_t});
  assign occ_wide = {11'd0, fill};
  assign src_wide = {3'd0, idx_r};
  assign base  = AW'(idx_r) * AW'(QUEUE_DEPTH);

  assign sts.deq_hit = (func_r == mrq_pkg::FUNC_DEQ) && found_r;
  assign ram_we      = cmd.exec && (func_r == mrq_pkg::FUNC_ENQ) && !full;

  mrq_ram #(
    .WIDTH (DESC_WIDTH),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base + AW'(cur_t)),
    .wdata (desc_r),
    .raddr (base + AW'(cur_h)),
    .rdata (ram_rdata)
  );

  assign dout_wide = {32'd0, ram_rdata};

  // control state: pointers and queue limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      qiu_r <= mrq_pkg::QIU_RESET;
    end else begin
      if (cfg_we) begin
        qiu_r <= cfg_wdata;
      end
      if (ram_we) begin
        tail_r[idx_r] <= t_adv;
      end
      if (cmd.exec && sts.deq_hit) begin
        head_r[idx_r] <= h_adv;
      end
    end
  end

  // operation and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_beat.func;
      found_r <= pick_found;
      idx_r   <= (in_beat.func == mrq_pkg::FUNC_DEQ) ? pick_idx : sel_idx;
      desc_r  <= din_wide[DESC_WIDTH-1:0];
    end
    if (cmd.exec) begin
      res_status_r <= mrq_pkg::ST_OK;
      res_desc_r   <= '0;
      res_src_r    <= '0;
      res_occ_r    <= '0;
      case (func_r)
        mrq_pkg::FUNC_ENQ: begin
          if (full) begin
            res_status_r <= mrq_pkg::ST_OVERFLOW;
          end
        end
        mrq_pkg::FUNC_DEQ: begin
          if (found_r) begin
            res_src_r <= src_wide[2:0];
          end else begin
            res_status_r <= mrq_pkg::ST_EMPTY;
          end
        end
        mrq_pkg::FUNC_OCC: begin
          res_occ_r <= occ_wide[10:0];
        end
        default: begin
          res_status_r <= mrq_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.finish) begin
      res_desc_r <= dout_wide[31:0];
    end
  end

  assign out_beat.status         = res_status_r;
  assign out_beat.descriptor_out = res_desc_r;
  assign out_beat.source_queue   = res_src_r;
  assign out_beat.occupancy      = res_occ_r;

endmodule

`default_nettype wire

@@ sv/multi_ring_queue_priority_dequeue.sv @@
// Top level: ring descriptor queues with highest-queue-first dequeue.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  mrq_pkg::in_beat_t
//   out_      output     out_valid/out_stall  mrq_pkg::out_beat_t
//   cfg_      input      cfg_we               cfg_wdata (queues in use)
//
// One beat at a time: after accept the block runs an execute state on the pointer
// registers, a wait state for the registered read of the descriptor store on a
// dequeue that finds an entry, then offers the result beat from the result
// register until it is taken; the next input beat is accepted only after that,
// so out_stall holds off new beats.
// Synchronous reset clears all pointers; the store needs no clearing pass.
// in_stall is high during reset, since its register resets high, and while a
// beat is in flight or waiting.
`timescale 1ns / 1ps
`default_nettype none

module multi_ring_queue_priority_dequeue #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 2048,
  parameter int DESC_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mrq_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mrq_pkg::out_beat_t      out_beat,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata
);

  mrq_pkg::mrq_cmd_t cmd;
  mrq_pkg::mrq_sts_t sts;

  mrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrq_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DESC_WIDTH  (DESC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire
